[hdl/vtgd_pkg.sv]
package vtgd_pkg;

  // Geometry command codes carried in the low bits of a header word
  localparam logic [2:0] CMD_MOVE  = 3'd1;
  localparam logic [2:0] CMD_LINE  = 3'd2;
  localparam logic [2:0] CMD_CLOSE = 3'd7;

  // Feature geometry types
  localparam logic [1:0] GT_POINT   = 2'd1;
  localparam logic [1:0] GT_POLYGON = 2'd3;

  // Configuration register indexes
  localparam logic REG_GEOMETRY_TYPE = 1'b0;

  // Operations handed from the front end to the back end
  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_LINE  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_POINT  = 3'd0;
  localparam logic [2:0] KIND_START  = 3'd1;
  localparam logic [2:0] KIND_VERTEX = 3'd2;
  localparam logic [2:0] KIND_OUTER  = 3'd3;
  localparam logic [2:0] KIND_INNER  = 3'd4;

  typedef struct packed {
    logic [1:0]  code;
    logic        point;
    logic        clear;
    logic [31:0] dx;
    logic [31:0] dy;
  } op_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [2:0]  kind;
  } result_t;

endpackage

[hdl/vector_tile_geometry_decoder_top.sv]
// Vector-tile geometry decoder. Push one 32-bit geometry stream word per transfer (header or
// zigzag parameter, new_feature set on the first word of a feature); pop vertices and ring
// classes from the result side. The block takes one word every clock cycle for as long as the
// result side keeps up: a front end parses headers and parameter pairs and queues decoded
// operations, and a back end moves the cursor, runs the shoelace winding product through a
// registered 33x33 multiplier and accumulates it into a 64-bit sum. A result that a transfer
// completes passes through the operation queue, the multiplier stage and the accumulate stage,
// which writes the result queue, before it shows on the result ports. The geometry_type register
// (APB, byte address 0) should only be changed while nothing is in flight.
module vector_tile_geometry_decoder_top
  import vtgd_pkg::*;
#(
  parameter int OP_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  // input stream
  input  logic               push,
  output logic               full,
  input  logic [31:0]        geometry_word,
  input  logic               new_feature,
  // result stream
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] vertex_x,
  output logic signed [31:0] vertex_y,
  output logic [2:0]         result_kind,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int OP_W  = $bits(op_t);
  localparam int RES_W = $bits(result_t);
  localparam int OCW   = $clog2(OP_DEPTH + 1);
  localparam int RCW   = $clog2(OUT_DEPTH + 1);

  logic [1:0]      geometry_type;
  logic            cfg_write;

  logic            front_take;
  logic            op_push;
  op_t             op_in;
  logic [OP_W-1:0] op_rdata;
  op_t             op_out;
  logic            op_empty;
  logic            op_ready;
  logic [OCW-1:0]  op_count;

  logic             res_valid;
  result_t          res_in;
  logic [RES_W-1:0] res_rdata;
  result_t          res_out;
  logic             res_full;
  logic [RCW-1:0]   res_count;

  // configuration: zero-wait writes, register index is the word address
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_GEOMETRY_TYPE) ? {30'd0, geometry_type} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_type <= 2'd0;
    end else if (cfg_write && paddr[2] == REG_GEOMETRY_TYPE) begin
      geometry_type <= pwdata[1:0];
    end
  end

  // hold the input whenever the operation queue cannot take another entry
  assign front_take = push && !full;

  vtgd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (front_take),
    .geometry_word (geometry_word),
    .new_feature   (new_feature),
    .geometry_type (geometry_type),
    .op_push       (op_push),
    .op            (op_in)
  );

  vtgd_queue #(
    .WIDTH (OP_W),
    .DEPTH (OP_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wdata (op_in),
    .full  (full),
    .pop   (op_ready),
    .rdata (op_rdata),
    .empty (op_empty),
    .count (op_count)
  );

  assign op_out = op_rdata;

  vtgd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (!op_empty),
    .op        (op_out),
    .op_ready  (op_ready),
    .out_count (res_count),
    .res_valid (res_valid),
    .res       (res_in)
  );

  vtgd_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty),
    .count (res_count)
  );

  assign res_out     = res_rdata;
  assign vertex_x    = res_out.x;
  assign vertex_y    = res_out.y;
  assign result_kind = res_out.kind;

`ifndef SYNTHESIS
  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !res_full)
    else $error("result dropped at a full result queue");

  a_op_drain: assert property (@(posedge clk) disable iff (rst)
    (op_count == '0) |-> op_empty)
    else $error("operation queue count and empty disagree");
`endif

endmodule

[hdl/vtgd_queue.sv]
module vtgd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wdata,
  output logic                           full,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rdata,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [IW-1:0]    wr_ptr;
  logic [IW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");
`endif

endmodule

[hdl/vtgd_front.sv]
module vtgd_front
  import vtgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [31:0] geometry_word,
  input  logic        new_feature,
  input  logic [1:0]  geometry_type,
  output logic        op_push,
  output op_t         op
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DX     = 2'd1;
  localparam logic [1:0] PH_DY     = 2'd2;
  localparam logic [1:0] PH_SPARE  = 2'd3;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [2:0]  command;
  logic [2:0]  command_next;
  logic [28:0] pairs_left;
  logic [28:0] pairs_left_next;
  logic [31:0] pending_dx;
  logic [31:0] pending_dx_next;
  logic        pending_clear;
  logic        pending_clear_next;

  function automatic logic [31:0] unzigzag(input logic [31:0] v);
    return {1'b0, v[31:1]} ^ {32{v[0]}};
  endfunction

  always_comb begin
    logic [1:0]  phase_e;
    logic [2:0]  command_e;
    logic [28:0] left_e;
    logic [2:0]  hdr_cmd;
    logic [28:0] hdr_count;

    phase_e   = new_feature ? PH_HEADER : phase;
    command_e = new_feature ? 3'd0 : command;
    left_e    = new_feature ? 29'd0 : pairs_left;
    hdr_cmd   = geometry_word[2:0];
    hdr_count = geometry_word[31:3];

    phase_next         = phase;
    command_next       = command;
    pairs_left_next    = pairs_left;
    pending_dx_next    = pending_dx;
    pending_clear_next = pending_clear;
    op_push            = 1'b0;
    op.code            = OP_MOVE;
    op.point           = (geometry_type == GT_POINT);
    op.clear           = pending_clear || new_feature;
    op.dx              = pending_dx;
    op.dy              = unzigzag(geometry_word);

    if (take) begin
      phase_next         = phase_e;
      command_next       = command_e;
      pairs_left_next    = left_e;
      pending_clear_next = pending_clear || new_feature;
      priority if (phase_e == PH_DX) begin
        pending_dx_next = unzigzag(geometry_word);
        phase_next      = PH_DY;
      end else if (phase_e == PH_DY) begin
        // finish the pair: hand it to the back end
        op_push         = 1'b1;
        op.code         = (command_e == CMD_MOVE) ? OP_MOVE : OP_LINE;
        pairs_left_next = left_e - 1'b1;
        phase_next      = (pairs_left_next == '0) ? PH_HEADER : PH_DX;
      end else begin
        phase_next = PH_HEADER;
        if ((hdr_cmd == CMD_MOVE || hdr_cmd == CMD_LINE) && hdr_count != '0) begin
          command_next    = hdr_cmd;
          pairs_left_next = hdr_count;
          phase_next      = PH_DX;
        end else if (hdr_cmd == CMD_CLOSE && hdr_count != '0 &&
                     geometry_type == GT_POLYGON) begin
          op_push = 1'b1;
          op.code = OP_CLOSE;
        end
      end
      if (op_push) begin
        pending_clear_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      command       <= 3'd0;
      pairs_left    <= '0;
      pending_dx    <= '0;
      pending_clear <= 1'b0;
    end else begin
      phase         <= phase_next;
      command       <= command_next;
      pairs_left    <= pairs_left_next;
      pending_dx    <= pending_dx_next;
      pending_clear <= pending_clear_next;
    end
  end

`ifndef SYNTHESIS
  a_dx_has_pairs: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DX || phase == PH_DY) |-> (pairs_left != '0))
    else $error("parameter phase with no pairs left");

  a_no_spare_phase: assert property (@(posedge clk) disable iff (rst)
    phase != PH_SPARE)
    else $error("spare parse phase entered");

  a_clear_consumed: assert property (@(posedge clk) disable iff (rst)
    op_push |=> !pending_clear || $past(1'b0))
    else $error("feature clear not consumed by pushed op");
`endif

endmodule

[hdl/vtgd_back.sv]
module vtgd_back
  import vtgd_pkg::*;
#(
  parameter int OUT_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               op_valid,
  input  op_t                                op,
  output logic                               op_ready,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  output logic                               res_valid,
  output result_t                            res
);

  localparam int CW  = $clog2(OUT_DEPTH + 1);
  localparam int CW1 = CW + 1;

  typedef struct packed {
    logic        close;
    logic        sum_clr;
    logic        add;
    logic [2:0]  kind;
    logic [31:0] x;
    logic [31:0] y;
  } ctl_t;

  logic        v1;
  logic        v2;
  ctl_t        s1_ctl;
  ctl_t        s2_ctl;
  logic [32:0] s1_ea;
  logic [32:0] s1_eb;
  logic [63:0] s2_prod;

  logic [31:0] cursor_x;
  logic [31:0] cursor_y;
  logic [31:0] ring_x;
  logic [31:0] ring_y;
  logic        ring_open;
  logic [63:0] winding_sum;

  logic        take;
  ctl_t        a_ctl;
  logic [32:0] a_ea;
  logic [32:0] a_eb;
  logic [31:0] cursor_x_next;
  logic [31:0] cursor_y_next;
  logic [31:0] ring_x_next;
  logic [31:0] ring_y_next;
  logic        ring_open_next;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  logic [63:0] sum_base;
  logic [63:0] sum_total;

  // admit an op only when the result queue has a slot for it and everything in flight
  assign op_ready = (CW1'(out_count) + CW1'(v1) + CW1'(v2)) < CW1'(OUT_DEPTH);
  assign take     = op_valid && op_ready;

  always_comb begin
    logic [31:0] cx;
    logic [31:0] cy;
    logic        open_e;
    logic [31:0] nx;
    logic [31:0] ny;

    cx     = op.clear ? 32'd0 : cursor_x;
    cy     = op.clear ? 32'd0 : cursor_y;
    open_e = op.clear ? 1'b0 : ring_open;
    nx     = cx + op.dx;
    ny     = cy + op.dy;

    cursor_x_next  = cx;
    cursor_y_next  = cy;
    ring_x_next    = op.clear ? 32'd0 : ring_x;
    ring_y_next    = op.clear ? 32'd0 : ring_y;
    ring_open_next = open_e;
    a_ea           = '0;
    a_eb           = '0;
    a_ctl.close    = 1'b0;
    a_ctl.sum_clr  = 1'b0;
    a_ctl.add      = 1'b0;
    a_ctl.kind     = KIND_VERTEX;
    a_ctl.x        = nx;
    a_ctl.y        = ny;

    unique case (op.code)
      OP_MOVE: begin
        cursor_x_next  = nx;
        cursor_y_next  = ny;
        ring_x_next    = nx;
        ring_y_next    = ny;
        ring_open_next = 1'b1;
        a_ctl.sum_clr  = 1'b1;
        a_ctl.kind     = op.point ? KIND_POINT : KIND_START;
      end
      OP_LINE: begin
        cursor_x_next = nx;
        cursor_y_next = ny;
        if (!open_e) begin
          // open the ring at the cursor as it was before this edge
          ring_x_next    = cx;
          ring_y_next    = cy;
          ring_open_next = 1'b1;
          a_ctl.sum_clr  = 1'b1;
        end
        a_ea      = {nx[31], nx} - {cx[31], cx};
        a_eb      = {ny[31], ny} + {cy[31], cy};
        a_ctl.add = 1'b1;
      end
      OP_CLOSE: begin
        a_ctl.close    = 1'b1;
        a_ctl.x        = cx;
        a_ctl.y        = cy;
        ring_open_next = 1'b0;
        a_ctl.sum_clr  = !open_e;
        a_ctl.add      = open_e;
        a_ea = {ring_x_next[31], ring_x_next} - {cx[31], cx};
        a_eb = {ring_y_next[31], ring_y_next} + {cy[31], cy};
      end
      default: begin
        a_ctl.close   = 1'b1;
        a_ctl.sum_clr = 1'b1;
      end
    endcase
  end

  assign mul_a = s1_ea;
  assign mul_b = s1_eb;
  assign mul_p = mul_a * mul_b;

  assign sum_base  = s2_ctl.sum_clr ? 64'd0 : winding_sum;
  assign sum_total = sum_base + (s2_ctl.add ? s2_prod : 64'd0);

  always_comb begin
    res_valid = v2;
    res.x     = s2_ctl.x;
    res.y     = s2_ctl.y;
    res.kind  = s2_ctl.kind;
    if (s2_ctl.close) begin
      res.kind = (sum_total == 64'd0 || sum_total[63]) ? KIND_OUTER : KIND_INNER;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl  <= a_ctl;
    s1_ea   <= a_ea;
    s1_eb   <= a_eb;
    s2_ctl  <= s1_ctl;
    s2_prod <= mul_p[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      cursor_x    <= '0;
      cursor_y    <= '0;
      ring_x      <= '0;
      ring_y      <= '0;
      ring_open   <= 1'b0;
      winding_sum <= '0;
    end else begin
      v1 <= take;
      v2 <= v1;
      if (take) begin
        cursor_x  <= cursor_x_next;
        cursor_y  <= cursor_y_next;
        ring_x    <= ring_x_next;
        ring_y    <= ring_y_next;
        ring_open <= ring_open_next;
      end
      if (v2) begin
        winding_sum <= s2_ctl.close ? 64'd0 : sum_total;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (out_count < CW'(OUT_DEPTH)))
    else $error("result written into a full queue");

  a_close_clears_sum: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2_ctl.close) |=> (winding_sum == 64'd0))
    else $error("winding sum not cleared after close");

  a_close_keeps_cursor: assert property (@(posedge clk) disable iff (rst)
    (take && op.code == OP_CLOSE && !op.clear) |=> $stable(cursor_x) && $stable(cursor_y))
    else $error("close moved the cursor");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import vtgd_pkg::*;

  // Geometry types that the package does not name
  localparam logic [1:0] GT_UNKNOWN    = 2'd0;
  localparam logic [1:0] GT_LINESTRING = 2'd2;

  localparam logic [2:0] GEOMETRY_TYPE_ADDR = {REG_GEOMETRY_TYPE, 2'b00};

  // Settling time after the last result; give the pipe plenty of room
  localparam int DRAIN_CYCLES = 12;
  // Cycles without any transfer before the run is declared hung
  localparam int STALL_LIMIT  = 4000;

  typedef enum logic [1:0] {PH_HEADER, PH_DX, PH_DY} parse_phase_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               full;
  logic [31:0]        geometry_word;
  logic               new_feature;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic [2:0]         result_kind;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  vector_tile_geometry_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .geometry_word(geometry_word),
    .new_feature  (new_feature),
    .empty        (empty),
    .pop          (pop),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .result_kind  (result_kind),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow state: what the block should hold after every accepted word
  // ---------------------------------------------------------------------------
  logic [1:0]   geom_type;
  parse_phase_t phase;
  logic [2:0]   cur_cmd;
  logic [28:0]  pairs_left;
  logic [31:0]  cur_x, cur_y;
  logic [31:0]  pend_dx;
  logic [31:0]  ring_x, ring_y;
  logic         ring_open;
  logic [63:0]  winding;

  result_t expected_vertices[$];

  int mismatch_count = 0;
  int words_sent     = 0;
  int burst_left     = 0;
  int idle_cycles    = 0;
  bit fresh_feature  = 1'b0;

  // Receiver stall pattern
  int stall_mode = 0;
  int stall_left = 0;

  function automatic logic [31:0] unzig(input logic [31:0] v);
    return (v >> 1) ^ {32{v[0]}};
  endfunction

  function automatic logic [31:0] zz(input int d);
    return 32'((d <<< 1) ^ (d >>> 31));
  endfunction

  function automatic logic [31:0] hdr(input logic [2:0] c, input logic [28:0] n);
    return {n, c};
  endfunction

  // Shoelace edge term (x1 - x0) * (y1 + y0), sign-extended and wrapped at 64 bits
  function automatic logic [63:0] shoelace(input logic [31:0] x0, y0, x1, y1);
    logic [63:0] dx, sy;
    dx = {{32{x1[31]}}, x1} - {{32{x0[31]}}, x0};
    sy = {{32{y1[31]}}, y1} + {{32{y0[31]}}, y0};
    return dx * sy;
  endfunction

  // Append one result to the tail of the expected list
  function automatic void expect_result(input result_t r);
    expected_vertices.insert(expected_vertices.size(), r);
  endfunction

  function automatic void clear_feature_state();
    phase      = PH_HEADER;
    cur_cmd    = '0;
    pairs_left = '0;
    cur_x      = '0;
    cur_y      = '0;
    pend_dx    = '0;
    ring_x     = '0;
    ring_y     = '0;
    ring_open  = 1'b0;
    winding    = '0;
  endfunction

  // Advance the shadow decoder by one accepted word and queue any vertex or ring class
  function automatic void track_word(input logic [31:0] word, input logic nf);
    logic [31:0] old_x, old_y;
    logic [63:0] closing;
    logic [2:0]  kind;
    result_t     r;
    if (nf) clear_feature_state();
    case (phase)
      PH_DX: begin
        pend_dx = unzig(word);
        phase   = PH_DY;
      end
      PH_DY: begin
        old_x = cur_x;
        old_y = cur_y;
        cur_x = old_x + pend_dx;
        cur_y = old_y + unzig(word);
        if (cur_cmd == CMD_MOVE) begin
          // a move always opens a fresh ring at the new cursor
          ring_x    = cur_x;
          ring_y    = cur_y;
          ring_open = 1'b1;
          winding   = '0;
          kind      = (geom_type == GT_POINT) ? KIND_POINT : KIND_START;
        end else begin
          // a line with no open ring starts one where the cursor was
          if (!ring_open) begin
            ring_x    = old_x;
            ring_y    = old_y;
            ring_open = 1'b1;
            winding   = '0;
          end
          winding = winding + shoelace(old_x, old_y, cur_x, cur_y);
          kind    = KIND_VERTEX;
        end
        pairs_left = pairs_left - 1'b1;
        phase      = (pairs_left == 0) ? PH_HEADER : PH_DX;
        r.x = cur_x; r.y = cur_y; r.kind = kind;
        expect_result(r);
      end
      default: begin
        // header slot; the spare phase encoding falls in here as well
        phase = PH_HEADER;
        if ((word[2:0] == CMD_MOVE || word[2:0] == CMD_LINE) && word[31:3] != 0) begin
          cur_cmd    = word[2:0];
          pairs_left = word[31:3];
          phase      = PH_DX;
        end else if (word[2:0] == CMD_CLOSE && word[31:3] != 0 &&
                     geom_type == GT_POLYGON) begin
          closing   = ring_open ? winding + shoelace(cur_x, cur_y, ring_x, ring_y) : '0;
          kind      = (closing == 0 || closing[63]) ? KIND_OUTER : KIND_INNER;
          ring_open = 1'b0;
          winding   = '0;
          r.x = cur_x; r.y = cur_y; r.kind = kind;
          expect_result(r);
        end
      end
    endcase
  endfunction

  function automatic void report(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call, with bursts and random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] word, input logic nf);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      // a quarter of the bursts follow straight on, with no gap at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push          <= 1'b1;
    geometry_word <= word;
    new_feature   <= nf;
    // hold the word until the block takes it
    do @(posedge clk); while (full);
    track_word(word, nf);
    words_sent++;
  endtask

  // Send a word, flagging it as the start of a feature if one was just opened
  task automatic send_geo(input logic [31:0] word);
    send_word(word, fresh_feature);
    fresh_feature = 1'b0;
  endtask

  function automatic logic [31:0] rand_param();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return zz(int'($urandom_range(0, 255)) - 128);
    if (roll < 90) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFE;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic send_pairs(input int n);
    repeat (2 * n) send_geo(rand_param());
  endtask

  function automatic logic [2:0] unknown_cmd();
    logic [2:0] c;
    do c = 3'($urandom_range(0, 7));
    while (c == CMD_MOVE || c == CMD_LINE || c == CMD_CLOSE);
    return c;
  endfunction

  // Wait until every expected result has been taken and the pipe has settled
  task automatic wait_drain();
    push <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write geometry_type with the block idle, then read it back
  task automatic set_geometry_type(input logic [1:0] gt);
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GEOMETRY_TYPE_ADDR;
    pwdata  <= 32'(gt);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    geom_type = gt;
    // go straight into the setup phase of the read
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(gt)) report("geometry_type readback", 32'(gt), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Rings in a polygon: empty close, outer and inner winding, close counts above one,
  // a line with no open ring, and the extreme parameter words
  task automatic test_polygon_rings();
    set_geometry_type(GT_POLYGON);
    send_word(hdr(CMD_CLOSE, 1), 1'b1);
    send_word(hdr(CMD_MOVE, 1), 1'b0);
    send_word(zz(10), 1'b0);
    send_word(zz(-5), 1'b0);
    send_word(hdr(CMD_LINE, 2), 1'b0);
    send_word(zz(20), 1'b0);
    send_word(zz(0), 1'b0);
    send_word(zz(0), 1'b0);
    send_word(zz(20), 1'b0);
    send_word(hdr(CMD_CLOSE, 5), 1'b0);
    // second ring wound the other way
    send_word(hdr(CMD_MOVE, 1), 1'b0);
    send_word(zz(0), 1'b0);
    send_word(zz(0), 1'b0);
    send_word(hdr(CMD_LINE, 3), 1'b0);
    send_word(zz(0), 1'b0);
    send_word(zz(10), 1'b0);
    send_word(zz(10), 1'b0);
    send_word(zz(0), 1'b0);
    send_word(zz(0), 1'b0);
    send_word(zz(-10), 1'b0);
    send_word(hdr(CMD_CLOSE, 1), 1'b0);
    // ring opened by a line, closed by an all-ones header
    send_word(hdr(CMD_LINE, 1), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
  endtask

  // Headers that must produce nothing, and a feature restart on a parameter slot
  task automatic test_degenerate_headers();
    send_word(hdr(CMD_MOVE, 0), 1'b1);
    send_word(hdr(CMD_LINE, 0), 1'b0);
    send_word(hdr(CMD_CLOSE, 0), 1'b0);
    repeat (4) send_word(hdr(unknown_cmd(), 29'($urandom)), 1'b0);
    send_word(hdr(CMD_MOVE, 1), 1'b0);
    send_word(zz(7), 1'b0);
    // restart lands where dy was due, so this word is read as a header
    send_word(hdr(CMD_LINE, 1), 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(hdr(CMD_CLOSE, 1), 1'b0);
  endtask

  // Point kind, and closes ignored outside polygons
  task automatic test_other_geometry_types();
    set_geometry_type(GT_POINT);
    send_word(hdr(CMD_MOVE, 2), 1'b1);
    send_word(zz(5), 1'b0);
    send_word(zz(5), 1'b0);
    send_word(zz(-1), 1'b0);
    send_word(zz(2), 1'b0);
    send_word(hdr(CMD_CLOSE, 1), 1'b0);
    set_geometry_type(GT_LINESTRING);
    send_word(hdr(CMD_MOVE, 1), 1'b1);
    send_pairs(1);
    send_word(hdr(CMD_LINE, 1), 1'b0);
    send_pairs(1);
    send_word(hdr(CMD_CLOSE, 1), 1'b0);
    set_geometry_type(GT_UNKNOWN);
    send_word(hdr(CMD_MOVE, 1), 1'b1);
    send_pairs(1);
  endtask

  // One feature: mostly well-formed parts with random content, some noise, some
  // sequences cut short by the next feature
  task automatic send_random_feature();
    int parts, roll, n;
    fresh_feature = 1'b1;
    parts = $urandom_range(1, 4);
    repeat (parts) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
        send_geo(hdr(CMD_MOVE, 29'(n)));
        send_pairs(n);
        n = $urandom_range(0, 6);
        if (n != 0) begin
          send_geo(hdr(CMD_LINE, 29'(n)));
          send_pairs(n);
        end
        if ($urandom_range(0, 3) != 0)
          send_geo(hdr(CMD_CLOSE, ($urandom_range(0, 5) == 0) ? 29'($urandom) : 29'd1));
      end else if (roll < 85) begin
        n = $urandom_range(1, 4);
        send_geo(hdr(CMD_LINE, 29'(n)));
        send_pairs(n);
        if ($urandom_range(0, 1) != 0) send_geo(hdr(CMD_CLOSE, 29'd1));
      end else if (roll < 93) begin
        case ($urandom_range(0, 2))
          0: send_geo(hdr(unknown_cmd(), 29'($urandom)));
          1: send_geo(hdr(($urandom_range(0, 1) != 0) ? CMD_MOVE : CMD_LINE, 29'd0));
          default: begin
            send_word($urandom, 1'($urandom_range(0, 1)));
            fresh_feature = 1'b0;
          end
        endcase
      end else begin
        // truncated part: a large count, a few parameters, then drop the feature
        send_geo(hdr(($urandom_range(0, 1) != 0) ? CMD_MOVE : CMD_LINE,
                     29'($urandom) | 29'd1));
        repeat ($urandom_range(0, 5)) send_geo(rand_param());
        return;
      end
    end
  endtask

  task automatic test_random_features(input logic [1:0] gt, input int n_words);
    int target;
    set_geometry_type(gt);
    target = words_sent + n_words;
    while (words_sent < target) send_random_feature();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every transfer, stall on a pattern of windows
  // ---------------------------------------------------------------------------
  task automatic check_vertex();
    result_t want;
    if (expected_vertices.size() == 0) begin
      report("result with none pending, kind", '0, 32'(result_kind));
    end else begin
      want = expected_vertices.pop_front();
      if (vertex_x !== want.x) report("vertex_x", want.x, vertex_x);
      if (vertex_y !== want.y) report("vertex_y", want.y, vertex_y);
      if (result_kind !== want.kind) report("result_kind", 32'(want.kind), 32'(result_kind));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && pop && !empty) check_vertex();
    // pick a new stall window: free-running, coin-flip, one in four, or fully held off
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= (stall_left % 4 == 0);
      default: pop <= 1'b0;
    endcase
  end

  // Watchdog: count cycles in which neither side completes a transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    geometry_word = '0;
    new_feature   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    geom_type     = GT_UNKNOWN;
    clear_feature_state();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_polygon_rings();
    test_degenerate_headers();
    test_other_geometry_types();
    test_random_features(GT_POLYGON, 400);
    test_random_features(GT_LINESTRING, 300);
    test_random_features(GT_POINT, 300);
    test_random_features(GT_UNKNOWN, 250);
    test_random_features(GT_POLYGON, 300);

    // drop push, let every result come out and the pipe settle
    wait_drain();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
